// ----- rtl/core/pca_pkg.sv -----
// shared constants, interval table and sideband type for the arc contrast map
`default_nettype none

package pca_pkg;

  localparam int FRAC_BITS = 8;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 16;
  localparam int INT_W     = 8;
  localparam int BND_W     = INT_W + FRAC_BITS;
  localparam int ARC_W     = (BND_W > VAL_W) ? BND_W : VAL_W;
  localparam int ROOT_W    = ARC_W;
  localparam int SQ_W      = 2 * ARC_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int NUM_INT   = 10;
  localparam int K_W       = $clog2(NUM_INT + 1);

  localparam logic [CFG_W-1:0] THR_RESET = CFG_W'(3264);
  localparam logic [VAL_W-1:0] VAL_MAX   = {VAL_W{1'b1}};

  // interval ends on the fixed point scale
  localparam logic [ARC_W-1:0] ARC_END [NUM_INT+1] = '{
    ARC_W'(0 << FRAC_BITS),
    ARC_W'(3 << FRAC_BITS),
    ARC_W'(8 << FRAC_BITS),
    ARC_W'(16 << FRAC_BITS),
    ARC_W'(30 << FRAC_BITS),
    ARC_W'(49 << FRAC_BITS),
    ARC_W'(75 << FRAC_BITS),
    ARC_W'(107 << FRAC_BITS),
    ARC_W'(147 << FRAC_BITS),
    ARC_W'(196 << FRAC_BITS),
    ARC_W'(255 << FRAC_BITS)
  };

  typedef struct packed {
    logic             act;
    logic             up;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] e;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/pca_isqrt.sv -----
// pipelined integer square root, one result bit per stage, sideband carried along
`default_nettype none

module pca_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [pca_pkg::SQ_W-1:0]     rad,
  input  wire pca_pkg::side_t               side_in,
  output logic                              out_valid,
  output logic      [pca_pkg::ROOT_W-1:0]   root,
  output pca_pkg::side_t                    side_out
);

  localparam int NS = pca_pkg::ROOT_W;

  logic                        vld     [NS];
  logic [pca_pkg::REM_W-1:0]   rem_q   [NS];
  logic [pca_pkg::ROOT_W-1:0]  root_q  [NS];
  logic [pca_pkg::SQ_W-1:0]    rad_q   [NS];
  pca_pkg::side_t              side_q  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic                        vld_in;
    logic [pca_pkg::REM_W-1:0]   rem_in;
    logic [pca_pkg::ROOT_W-1:0]  root_in;
    logic [pca_pkg::SQ_W-1:0]    rad_in;
    pca_pkg::side_t              side_i;
    logic [pca_pkg::REM_W-1:0]   cur;
    logic [pca_pkg::REM_W-1:0]   trial;
    logic [pca_pkg::REM_W-1:0]   rem_next;
    logic [pca_pkg::ROOT_W-1:0]  root_next;

    if (j == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign side_i  = side_in;
    end else begin : g_rest
      assign vld_in  = vld[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign side_i  = side_q[j-1];
    end

    always_comb begin
      cur   = {rem_in[pca_pkg::REM_W-3:0], rad_in[pca_pkg::SQ_W-1 -: 2]};
      trial = {root_in, 2'b01};
      if (cur >= trial) begin
        rem_next  = cur - trial;
        root_next = {root_in[pca_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = cur;
        root_next = {root_in[pca_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= rem_next;
        root_q[j] <= root_next;
        rad_q[j]  <= {rad_in[pca_pkg::SQ_W-3:0], 2'b00};
        side_q[j] <= side_i;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign root      = root_q[NS-1];
  assign side_out  = side_q[NS-1];

endmodule

`default_nettype wire

// ----- rtl/core/piecewise_arc_contrast_map.sv -----
// top level of the piecewise arc contrast map: front stages, root pipeline, output buffer
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: voxel_value, edge_mean; tuser: is_molecule
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: mapped_value
// cfg      in   cfg_valid/cfg_ready          cfg_data: intensity_threshold
//
// one request per cycle while the output buffer is not full; the path runs through the
// four front stages, one stage per root bit of the 8.8 value in pca_isqrt and the output buffer.
// rst is synchronous; it empties the pipeline and buffer and reloads the threshold.
// the pipeline advances as a whole while the two-entry output buffer is not full,
// so s_axis_tready depends on registers only and a stall loses nothing.
`default_nettype none

module piecewise_arc_contrast_map (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] voxel_value, [31:16] edge_mean
  input  wire logic [0:0]  s_axis_tuser,   // [0] is_molecule
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [15:0] mapped_value
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int VW = pca_pkg::VAL_W;
  localparam int AW = pca_pkg::ARC_W;

  logic [pca_pkg::CFG_W-1:0] thr;
  logic [1:0]                cnt;
  logic                      en;

  assign en            = (cnt != 2'd2);
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= pca_pkg::THR_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // stage 1: threshold test and interval index
  logic [VW-1:0]          in_x;
  logic [VW-1:0]          in_e;
  logic [pca_pkg::K_W-1:0] k_next;
  logic                   v1;
  logic                   act1;
  logic [VW-1:0]          x1;
  logic [VW-1:0]          e1;
  logic [pca_pkg::K_W-1:0] k1;

  assign in_x = s_axis_tdata[15:0];
  assign in_e = s_axis_tdata[31:16];

  always_comb begin
    k_next = '0;
    for (int i = 1; i < pca_pkg::NUM_INT; i++) begin
      if (AW'(in_x) > pca_pkg::ARC_END[i]) begin
        k_next = pca_pkg::K_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= s_axis_tuser[0] && (in_x > thr);
      x1   <= in_x;
      e1   <= in_e;
      k1   <= k_next;
    end
  end

  // stage 2: arc radius and offset magnitudes
  logic [AW-1:0] lo_end;
  logic [AW-1:0] hi_end;
  logic          up_next;
  logic [AW:0]   d_diff;
  logic [AW:0]   t_diff;
  logic [AW-1:0] d_next;
  logic [AW-1:0] t_next;
  logic          v2;
  pca_pkg::side_t side2;
  logic [AW-1:0] d2;
  logic [AW-1:0] t2;

  always_comb begin
    lo_end  = pca_pkg::ARC_END[k1];
    hi_end  = pca_pkg::ARC_END[pca_pkg::K_W'(k1 + 1'b1)];
    up_next = (x1 <= e1);
    if (up_next) begin
      d_diff = {1'b0, AW'(e1)} - {1'b0, lo_end};
      t_diff = {1'b0, AW'(x1)} - {1'b0, lo_end};
    end else begin
      d_diff = {1'b0, hi_end} - {1'b0, AW'(e1)};
      t_diff = {1'b0, AW'(x1)} - {1'b0, hi_end};
    end
    d_next = d_diff[AW] ? AW'(-d_diff) : d_diff[AW-1:0];
    t_next = t_diff[AW] ? AW'(-t_diff) : t_diff[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= '{act: act1, up: up_next, x: x1, e: e1};
      d2    <= d_next;
      t2    <= t_next;
    end
  end

  // stage 3: squares
  logic                     v3;
  pca_pkg::side_t           side3;
  logic [pca_pkg::SQ_W-1:0] dsq3;
  logic [pca_pkg::SQ_W-1:0] tsq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side2;
      dsq3  <= pca_pkg::SQ_W'(d2 * d2);
      tsq3  <= pca_pkg::SQ_W'(t2 * t2);
    end
  end

  // stage 4: root argument, clamped at zero
  logic                     v4;
  pca_pkg::side_t           side4;
  logic [pca_pkg::SQ_W-1:0] rad4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side3;
      rad4  <= (dsq3 >= tsq3) ? (dsq3 - tsq3) : '0;
    end
  end

  logic                       vr;
  logic [pca_pkg::ROOT_W-1:0] root;
  pca_pkg::side_t             sider;

  pca_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .rad       (rad4),
    .side_in   (side4),
    .out_valid (vr),
    .root      (root),
    .side_out  (sider)
  );

  // move along the arc and saturate
  logic [AW:0]   sum_w;
  logic [AW:0]   dif_w;
  logic [VW-1:0] res;

  always_comb begin
    sum_w = {1'b0, AW'(sider.e)} + {1'b0, AW'(root)};
    dif_w = {1'b0, AW'(sider.e)} - {1'b0, AW'(root)};
    if (!sider.act) begin
      res = sider.x;
    end else if (sider.up) begin
      res = dif_w[AW] ? '0 : VW'(dif_w[AW-1:0]);
    end else if (sum_w > (AW + 1)'(pca_pkg::VAL_MAX)) begin
      res = pca_pkg::VAL_MAX;
    end else begin
      res = VW'(sum_w);
    end
  end

  // two-entry output buffer
  logic          push;
  logic          pop;
  logic [VW-1:0] slot0;
  logic [VW-1:0] slot1;

  assign push          = en && vr;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    priority if (push && pop) begin
      slot0 <= res;
    end else if (pop) begin
      slot0 <= slot1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");

  a_full_holds_input: assert property (@(posedge clk) disable iff (rst)
      (cnt == 2'd2) |-> !(s_axis_tvalid && s_axis_tready))
    else $error("request taken while output buffer full");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
      (push && !sider.act) |-> (res == sider.x))
    else $error("unmapped voxel altered");

  a_arc_below: assert property (@(posedge clk) disable iff (rst)
      (push && sider.act && sider.up) |-> (res <= sider.e))
    else $error("lower arc result above edge mean");

  a_arc_above: assert property (@(posedge clk) disable iff (rst)
      (push && sider.act && !sider.up) |-> (res >= sider.e))
    else $error("upper arc result below edge mean");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// testbench for the piecewise arc contrast map: directed and random voxel streams checked against a predictor

module tb;

  localparam int FRAC  = pca_pkg::FRAC_BITS;
  localparam int DRAIN = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] voxel_value, [31:16] edge_mean
  logic [0:0]  s_axis_tuser = '0;   // [0] is_molecule
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] mapped_value
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  logic [15:0] mapped_q [$];
  logic [15:0] want;
  logic [15:0] thr_model = 16'd3264;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  piecewise_arc_contrast_map u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // interval ends on the integer grey scale
  function automatic int knot(input int i);
    case (i)
      0: return 0;
      1: return 3;
      2: return 8;
      3: return 16;
      4: return 30;
      5: return 49;
      6: return 75;
      7: return 107;
      8: return 147;
      9: return 196;
      default: return 255;
    endcase
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint r, c;
    int b;
    r = 0;
    for (b = 17; b >= 0; b--) begin
      c = r | (longint'(1) << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [15:0] arc_map(input logic [15:0] x, input logic [15:0] e,
                                          input logic mol, input logic [15:0] thr);
    longint xv, ev, lo, hi, rad, res;
    int k, i;
    xv = x;
    ev = e;
    res = xv;
    if (mol && x > thr) begin
      k = 0;
      for (i = 1; i <= 9; i++)
        if (xv > (longint'(knot(i)) << FRAC)) k = i;
      lo = longint'(knot(k)) << FRAC;
      hi = longint'(knot(k + 1)) << FRAC;
      if (xv <= ev) rad = (ev - lo) * (ev - lo) - (xv - lo) * (xv - lo);
      else rad = (hi - ev) * (hi - ev) - (xv - hi) * (xv - hi);
      if (rad < 0) rad = 0;
      res = (xv <= ev) ? ev - floor_sqrt(rad) : ev + floor_sqrt(rad);
      if (res < 0) res = 0;
      if (res > 65535) res = 65535;
    end
    return res[15:0];
  endfunction

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (mapped_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = mapped_q.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: mapped_value mismatch, expected %h, actual %h",
                   $time, want, m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_voxel(input logic [15:0] x, input logic [15:0] e, input logic mol);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e, x};
    s_axis_tuser  <= mol;
    do @(posedge clk); while (!s_axis_tready);
    mapped_q.push_back(arc_map(x, e, mol, thr_model));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] thr);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = thr;
  endtask

  task automatic test_default_threshold();
    send_voxel(16'd3264, 16'd5000, 1'b1);
    send_voxel(16'd3265, 16'd5000, 1'b1);
    send_voxel(16'd4000, 16'hffff, 1'b0);
    // voxel above the top end: offset measured past the last interval end
    send_voxel(16'hffff, 16'h0000, 1'b1);
    send_voxel(16'hffff, 16'hffff, 1'b1);
    send_voxel(16'hff00, 16'h8000, 1'b1);
    send_voxel(16'(16 << FRAC), 16'(20 << FRAC), 1'b1);
    send_voxel(16'((16 << FRAC) + 1), 16'(10 << FRAC), 1'b1);
    send_voxel(16'(30 << FRAC), 16'(30 << FRAC), 1'b1);
    // edge mean above the interval end
    send_voxel(16'(50 << FRAC), 16'(200 << FRAC), 1'b1);
    send_voxel(16'(100 << FRAC), 16'h0000, 1'b1);
    send_voxel(16'h5555, 16'haaaa, 1'b1);
    send_voxel(16'haaaa, 16'h5555, 1'b1);
  endtask

  task automatic test_threshold_edges();
    write_threshold(16'd0);
    send_voxel(16'd0, 16'd100, 1'b1);
    send_voxel(16'd1, 16'd0, 1'b1);
    send_voxel(16'(3 << FRAC), 16'(1 << FRAC), 1'b1);
    send_voxel(16'(2 << FRAC), 16'hffff, 1'b1);
    send_voxel(16'(150 << FRAC), 16'(147 << FRAC), 1'b1);
    send_voxel(16'(197 << FRAC), 16'(255 << FRAC), 1'b1);
    send_voxel(16'd500, 16'd0, 1'b0);
    write_threshold(16'hffff);
    send_voxel(16'hffff, 16'd0, 1'b1);
    send_voxel(16'hfffe, 16'd0, 1'b1);
  endtask

  task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                    input logic [15:0] thr, input int count);
    logic [15:0] x, e;
    logic        mol;
    int          n, k, t;
    write_threshold(thr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1: begin
          x = 16'($urandom);
          e = 16'($urandom);
        end
        2, 3, 4, 5: begin
          k = $urandom_range(9);
          x = 16'((knot(k) << FRAC) + $urandom_range((knot(k + 1) - knot(k)) << FRAC));
          e = 16'($urandom_range(255 << FRAC));
        end
        6, 7: begin
          t = (knot($urandom_range(10)) << FRAC) + int'($urandom_range(2)) - 1;
          x = 16'((t < 0) ? 0 : t);
          e = 16'($urandom);
        end
        default: begin
          x = 16'($urandom);
          t = int'(x) + int'($urandom_range(64)) - 32;
          e = 16'((t < 0) ? 0 : (t > 65535) ? 65535 : t);
        end
      endcase
      mol = ($urandom_range(3) != 0);
      send_voxel(x, e, mol);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_threshold();
    test_threshold_edges();
    test_random_stream(0, 0, 16'd3264, 130);
    test_random_stream(49, 0, 16'd0, 130);
    test_random_stream(0, 49, 16'($urandom_range(16'h2000)), 130);
    test_random_stream(28, 28, 16'($urandom), 130);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
